FILE: src/ftc_pkg.sv
// Package for the focuser temperature compensation block.
// Holds the temperature type, the validation limits, register indexes and the state record.
// No dependencies.
package ftc_pkg;

  localparam int unsigned TEMP_W = 12;
  localparam int unsigned COEF_W = 16;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ADDR_W = 5;

  typedef logic signed [TEMP_W-1:0] temp_t;

  // Valid readings lie strictly between -40 C and 80 C (1/16 C units)
  localparam temp_t TEMP_LOW_EXCL  = -12'sd640;
  localparam temp_t TEMP_HIGH_EXCL = 12'sd1280;
  localparam temp_t DEFAULT_TEMP_RST = 12'sd320;
  localparam logic signed [TEMP_W:0] ONE_DEGREE = 13'sd16;

  typedef enum logic [2:0] {
    REG_PROBE_LOADED = 3'd0,
    REG_DIRECTION    = 3'd1,
    REG_STEP_COEF    = 3'd2,
    REG_MAX_STEP     = 3'd3,
    REG_DEFAULT_TEMP = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic  read_phase;
    logic  prev_enable;
    temp_t last_valid;
    temp_t held;
    temp_t start;
  } ftc_state_t;

endpackage

FILE: src/ftc_step.sv
// Per-tick compensation datapath: validation, phase handling, move and clamp.
// Pure combinational; uses ftc_pkg.
module ftc_step
  import ftc_pkg::*;
#(
  parameter int unsigned PosBits = 24
) (
  input  ftc_state_t          state_i,
  input  logic                probe_loaded_i,
  input  logic                direction_inward_i,
  input  logic [COEF_W-1:0]   step_coefficient_i,
  input  logic [PosBits-1:0]  max_step_i,
  input  temp_t               temp_sample_i,
  input  logic                comp_enable_i,
  input  logic [PosBits-1:0]  target_position_i,
  output ftc_state_t          state_o,
  output temp_t               temperature_o,
  output logic [PosBits-1:0]  new_target_o,
  output logic                target_moved_o,
  output logic                request_conversion_o
);

  logic                     sample_ok;
  temp_t                    vtemp;
  temp_t                    start1;
  temp_t                    held1;
  logic signed [TEMP_W:0]   diff;
  logic                     big_change;
  logic                     falling;
  logic                     subtract;
  logic [PosBits-1:0]       coef_ext;
  logic [PosBits:0]         pos_add;
  logic [PosBits:0]         pos_sel;
  logic [PosBits-1:0]       pos_clamped;
  logic                     move;

  always_comb begin
    sample_ok = (temp_sample_i > TEMP_LOW_EXCL) && (temp_sample_i < TEMP_HIGH_EXCL);
    vtemp     = sample_ok ? temp_sample_i : state_i.last_valid;

    start1 = (comp_enable_i && !state_i.prev_enable) ? vtemp : state_i.start;
    held1  = state_i.read_phase ? vtemp : state_i.held;

    diff       = {start1[TEMP_W-1], start1} - {held1[TEMP_W-1], held1};
    big_change = (diff >= ONE_DEGREE) || (diff <= -ONE_DEGREE);
    falling    = held1 < start1;
    subtract   = direction_inward_i ? falling : !falling;
    move       = comp_enable_i && big_change;

    coef_ext = PosBits'(step_coefficient_i);
    pos_add  = {1'b0, target_position_i} + {1'b0, coef_ext};
    if (subtract) begin
      // Floor at zero
      pos_sel = (target_position_i < coef_ext) ? '0
                                               : {1'b0, target_position_i - coef_ext};
    end else begin
      pos_sel = pos_add;
    end
    pos_clamped = (pos_sel > {1'b0, max_step_i}) ? max_step_i : pos_sel[PosBits-1:0];
  end

  always_comb begin
    state_o              = state_i;
    temperature_o        = state_i.last_valid;
    new_target_o         = target_position_i;
    target_moved_o       = 1'b0;
    request_conversion_o = 1'b0;
    if (probe_loaded_i) begin
      state_o.prev_enable = comp_enable_i;
      if (sample_ok && ((comp_enable_i && !state_i.prev_enable) || state_i.read_phase)) begin
        state_o.last_valid = temp_sample_i;
      end
      state_o.read_phase   = !state_i.read_phase;
      state_o.held         = held1;
      state_o.start        = move ? held1 : start1;
      temperature_o        = held1;
      request_conversion_o = !state_i.read_phase;
      target_moved_o       = move;
      if (move) begin
        new_target_o = pos_clamped;
      end
    end
  end

endmodule

FILE: src/focuser_temperature_compensation.sv
// Top level of the focuser temperature compensation block.
// Input register, ftc_step datapath, output register and the APB register file; uses ftc_pkg.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one tick: probe sample,
//   compensation enable and the current target. Output channel
//   (out_valid_o/out_ready_i) returns one result per tick: reported
//   temperature, new target, moved flag and the conversion request.
//   A tick lands in the input register, passes the combinational ftc_step
//   datapath and is held in the output register. Throughput is
//   one tick per cycle; the input register accepts a new tick whenever the
//   output register is empty or is being drained in the same cycle.
//   When the receiver stalls, the result holds in the output register and the
//   input register takes one more tick before in_ready_o drops.
//   Reset clears both pipeline stages, sets the registers to their defaults
//   (probe not loaded, inward direction, zero coefficient, full clamp, 20 C)
//   and starts on a request phase. Program the APB registers only while no
//   transaction is in flight; writing default_temp also reloads the last
//   valid temperature.
module focuser_temperature_compensation
  import ftc_pkg::*;
#(
  parameter int unsigned POS_BITS = 24
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  temp_t               temp_sample_i,
  input  logic                comp_enable_i,
  input  logic [POS_BITS-1:0] target_position_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output temp_t               temperature_o,
  output logic [POS_BITS-1:0] new_target_o,
  output logic                target_moved_o,
  output logic                request_conversion_o
);

  logic                probe_loaded_q;
  logic                direction_inward_q;
  logic [COEF_W-1:0]   step_coefficient_q;
  logic [POS_BITS-1:0] max_step_q;
  temp_t               default_temp_q;

  ftc_state_t          state_q, state_d;

  logic                s0_valid_q;
  temp_t               s0_sample_q;
  logic                s0_enable_q;
  logic [POS_BITS-1:0] s0_target_q;

  logic                out_valid_q;
  temp_t               out_temp_q, out_temp_d;
  logic [POS_BITS-1:0] out_target_q, out_target_d;
  logic                out_moved_q, out_moved_d;
  logic                out_req_q, out_req_d;

  logic                cfg_write;
  logic [2:0]          cfg_idx;
  logic                advance;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_idx   = paddr[ADDR_W-1:2];

  assign advance    = s0_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s0_valid_q || advance;

  always_comb begin
    unique case (cfg_idx)
      REG_PROBE_LOADED: prdata = DATA_W'(probe_loaded_q);
      REG_DIRECTION:    prdata = DATA_W'(direction_inward_q);
      REG_STEP_COEF:    prdata = DATA_W'(step_coefficient_q);
      REG_MAX_STEP:     prdata = DATA_W'(max_step_q);
      REG_DEFAULT_TEMP: prdata = DATA_W'(default_temp_q);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_loaded_q     <= 1'b0;
      direction_inward_q <= 1'b1;
      step_coefficient_q <= '0;
      max_step_q         <= '1;
      default_temp_q     <= DEFAULT_TEMP_RST;
    end else if (cfg_write) begin
      unique case (cfg_idx)
        REG_PROBE_LOADED: probe_loaded_q     <= pwdata[0];
        REG_DIRECTION:    direction_inward_q <= pwdata[0];
        REG_STEP_COEF:    step_coefficient_q <= pwdata[COEF_W-1:0];
        REG_MAX_STEP:     max_step_q         <= pwdata[POS_BITS-1:0];
        REG_DEFAULT_TEMP: default_temp_q     <= pwdata[TEMP_W-1:0];
        default: ;
      endcase
    end
  end

  ftc_step #(
    .PosBits (POS_BITS)
  ) u_step (
    .state_i              (state_q),
    .probe_loaded_i       (probe_loaded_q),
    .direction_inward_i   (direction_inward_q),
    .step_coefficient_i   (step_coefficient_q),
    .max_step_i           (max_step_q),
    .temp_sample_i        (s0_sample_q),
    .comp_enable_i        (s0_enable_q),
    .target_position_i    (s0_target_q),
    .state_o              (state_d),
    .temperature_o        (out_temp_d),
    .new_target_o         (out_target_d),
    .target_moved_o       (out_moved_d),
    .request_conversion_o (out_req_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.read_phase  <= 1'b0;
      state_q.prev_enable <= 1'b0;
      state_q.last_valid  <= DEFAULT_TEMP_RST;
      state_q.held        <= '0;
      state_q.start       <= '0;
    end else if (cfg_write && (cfg_idx == REG_DEFAULT_TEMP)) begin
      state_q.last_valid <= pwdata[TEMP_W-1:0];
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s0_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s0_sample_q <= temp_sample_i;
      s0_enable_q <= comp_enable_i;
      s0_target_q <= target_position_i;
    end
    if (advance) begin
      out_temp_q   <= out_temp_d;
      out_target_q <= out_target_d;
      out_moved_q  <= out_moved_d;
      out_req_q    <= out_req_d;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign temperature_o        = out_temp_q;
  assign new_target_o         = out_target_q;
  assign target_moved_o       = out_moved_q;
  assign request_conversion_o = out_req_q;

  // Without a probe nothing moves and no conversion is requested
  a_no_probe_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !probe_loaded_q |=> !target_moved_o && !request_conversion_o)
    else $error("activity reported without a probe");

  // Each processed tick with a probe flips the phase, unless a default_temp write lands in the same cycle
  a_phase_toggles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && probe_loaded_q && !cfg_write
      |=> state_q.read_phase != $past(state_q.read_phase))
    else $error("phase did not advance");

  // A moved target never exceeds the clamp
  a_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && target_moved_o |-> new_target_o <= max_step_q)
    else $error("moved target above max_step");

  // A request phase result always follows a read phase state of zero
  a_request_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && probe_loaded_q && !cfg_write |=> request_conversion_o == state_q.read_phase)
    else $error("request flag out of step with phase");

endmodule
